// ===== rtl/core/ctst_pkg.sv =====
// Package for the connection tracking state table.
// Item types, state and command codes, transition helpers and timeout defaults.
// No dependencies.
package ctst_pkg;

  localparam int SLOT_W    = 14;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int THR_W     = 37;

  // commands
  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_PACKET = 2'd1;
  localparam logic [1:0] CMD_AGE    = 2'd2;

  // protocol classes
  localparam logic [1:0] PROTO_TCP = 2'd0;
  localparam logic [1:0] PROTO_UDP = 2'd1;

  // connection states
  localparam logic [3:0] ST_CLOSED    = 4'd0;
  localparam logic [3:0] ST_NEW       = 4'd1;
  localparam logic [3:0] ST_SIMSYN    = 4'd2;
  localparam logic [3:0] ST_SYNRCVD   = 4'd3;
  localparam logic [3:0] ST_EST       = 4'd4;
  localparam logic [3:0] ST_FINSENT   = 4'd5;
  localparam logic [3:0] ST_FINRCVD   = 4'd6;
  localparam logic [3:0] ST_CLOSEWAIT = 4'd7;
  localparam logic [3:0] ST_FINWAIT   = 4'd8;
  localparam logic [3:0] ST_CLOSING   = 4'd9;
  localparam logic [3:0] ST_LASTACK   = 4'd10;
  localparam logic [3:0] ST_TIMEWAIT  = 4'd11;

  // flag classes
  localparam logic [2:0] FC_INV    = 3'd0;
  localparam logic [2:0] FC_SYN    = 3'd1;
  localparam logic [2:0] FC_SYNACK = 3'd2;
  localparam logic [2:0] FC_ACK    = 3'd3;
  localparam logic [2:0] FC_FIN    = 3'd4;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_CLOSED_TMO = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NEW_TMO    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_UDP_EST    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TCP_EST    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HALF_CLOSE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TIME_WAIT  = 3'd5;

  localparam logic [CFG_W-1:0] RST_CLOSED_TMO = 16'd5;
  localparam logic [CFG_W-1:0] RST_NEW_TMO    = 16'd5;
  localparam logic [CFG_W-1:0] RST_UDP_EST    = 16'd30;
  localparam logic [CFG_W-1:0] RST_TCP_EST    = 16'd300;
  localparam logic [CFG_W-1:0] RST_HALF_CLOSE = 16'd120;
  localparam logic [CFG_W-1:0] RST_TIME_WAIT  = 16'd30;

  localparam logic [31:0]      FLAG_CLASS_LUT = 32'h0243_0140;
  localparam logic [19:0]      US_PER_S       = 20'd1000000;
  localparam logic [15:0]      DNS_PORT       = 16'd53;
  localparam logic [CFG_W-1:0] DNS_TMO_S      = 16'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        proto_class;
    logic [15:0]       fwd_port;
    logic              reverse_dir;
    logic [7:0]        flag_byte;
    logic [63:0]       now_us;
  } in_item_t;

  typedef struct packed {
    logic [3:0] conn_state;
    logic       entry_valid;
    logic       expired;
  } out_item_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic        valid;
    logic [3:0]  state;
    logic [1:0]  proto;
    logic        dns;
    logic [63:0] last_us;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic clr_we;
    logic capture;
    logic eval;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
  } dp_status_t;

  // fold raw flags into a flag class
  function automatic logic [2:0] flag_class(input logic [7:0] flags);
    logic [2:0] s;
    s = {flags[4], flags[1:0]};
    return FLAG_CLASS_LUT[{s, 2'b00} +: 3];
  endfunction

  // tcp transition row, one nibble per flag class (class 0 in the low nibble)
  function automatic logic [19:0] tcp_row(input logic [3:0] st, input logic dir);
    logic [19:0] row;
    case ({st, dir})
      {ST_CLOSED, 1'b0}:    row = 20'h00010;
      {ST_NEW, 1'b0}:       row = 20'h00010;
      {ST_NEW, 1'b1}:       row = 20'h00320;
      {ST_SIMSYN, 1'b0}:    row = 20'h00320;
      {ST_SIMSYN, 1'b1}:    row = 20'h60320;
      {ST_SYNRCVD, 1'b0}:   row = 20'h54030;
      {ST_SYNRCVD, 1'b1}:   row = 20'h63300;
      {ST_EST, 1'b0}:       row = 20'h54000;
      {ST_EST, 1'b1}:       row = 20'h64000;
      {ST_FINSENT, 1'b0}:   row = 20'h55000;
      {ST_FINSENT, 1'b1}:   row = 20'h98000;
      {ST_FINRCVD, 1'b0}:   row = 20'h97000;
      {ST_FINRCVD, 1'b1}:   row = 20'h66000;
      {ST_CLOSEWAIT, 1'b0}: row = 20'hA7000;
      {ST_CLOSEWAIT, 1'b1}: row = 20'hA7000;
      {ST_FINWAIT, 1'b0}:   row = 20'hA8000;
      {ST_FINWAIT, 1'b1}:   row = 20'hA8000;
      {ST_CLOSING, 1'b0}:   row = 20'h0A000;
      {ST_CLOSING, 1'b1}:   row = 20'h0A000;
      {ST_LASTACK, 1'b0}:   row = 20'h0B000;
      {ST_LASTACK, 1'b1}:   row = 20'h0B000;
      {ST_TIMEWAIT, 1'b0}:  row = 20'h00010;
      default:              row = 20'h00000;
    endcase
    return row;
  endfunction

  function automatic logic [3:0] next_state(input logic [3:0] st, input logic [1:0] proto,
                                            input logic dir, input logic [7:0] flags);
    logic [19:0] row;
    logic [3:0]  nst;
    row = tcp_row(st, dir);
    if (proto == PROTO_TCP) begin
      case (flag_class(flags))
        FC_INV:    nst = row[3:0];
        FC_SYN:    nst = row[7:4];
        FC_SYNACK: nst = row[11:8];
        FC_ACK:    nst = row[15:12];
        FC_FIN:    nst = row[19:16];
        default:   nst = ST_CLOSED;
      endcase
    end else begin
      case (st)
        ST_CLOSED: nst = dir ? ST_CLOSED : ST_NEW;
        ST_NEW:    nst = dir ? ST_EST : ST_NEW;
        ST_EST:    nst = ST_EST;
        default:   nst = ST_CLOSED;
      endcase
    end
    return nst;
  endfunction

endpackage

// ===== rtl/core/tcp_udp_conntrack_state_table.sv =====
// Top level of the connection tracking state table.
// Depends on ctst_pkg, ctst_ctrl, ctst_dp.
//
// An item is taken when start is high and busy is low. The slot's memory word
// is read at the accepting edge, the next state, elapsed time and expiry
// threshold are evaluated and registered in state S_READ, and the slot is
// written back in state S_WB; busy stays high through S_READ and S_WB, so a
// new item is taken only after the last one is written back. The single result
// appears on out_item with out_strobe for exactly one cycle, registered at the
// write-back; it must be captured then, there is no backpressure. After reset
// the block clears every slot, one per cycle, with busy high; configuration
// writes are taken at any time, but a write of zero is ignored.
module tcp_udp_conntrack_state_table #(
  parameter int MAX_CONNS = 16384
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  ctst_pkg::in_item_t             in_item,
  output logic                           out_strobe,
  output ctst_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ctst_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [ctst_pkg::CFG_W-1:0]     cfg_data
);
  import ctst_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // registers always accept a write; a write of zero leaves them unchanged
  assign cfg_ready = 1'b1;

  ctst_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  ctst_dp #(
    .MAX_CONNS (MAX_CONNS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== rtl/core/ctst_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module ctst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/core/ctst_ctrl.sv =====
// Controller for the connection tracking state table: clear, read, write-back.
// Depends on ctst_pkg.
module ctst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ctst_pkg::dp_status_t status,
  output ctst_pkg::ctrl_cmd_t  cmd
);
  import ctst_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_WB    = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // command decode
  always_comb begin
    cmd.clr_we  = (state_r == S_CLEAR);
    cmd.capture = start && (state_r == S_IDLE);
    cmd.eval    = (state_r == S_READ);
    cmd.commit  = (state_r == S_WB);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_READ;
      S_CLEAR: if (status.clr_done) state_nxt = S_IDLE;
      S_READ:  state_nxt = S_WB;
      S_WB:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/ctst_dp.sv =====
// Datapath for the connection tracking state table: slot memory, timeout
// registers, transition and expiry evaluation, result register. Depends on ctst_pkg, ctst_ram.
module ctst_dp #(
  parameter int MAX_CONNS = 16384
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ctst_pkg::ctrl_cmd_t                 cmd,
  output ctst_pkg::dp_status_t                status,
  input  ctst_pkg::in_item_t                  in_item,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [ctst_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [ctst_pkg::CFG_W-1:0]          cfg_data,
  output logic                                out_strobe,
  output ctst_pkg::out_item_t                 out_item
);
  import ctst_pkg::*;

  localparam int AW = $clog2(MAX_CONNS);

  // timeout registers
  logic [CFG_W-1:0] closed_tmo_r, new_tmo_r, udp_est_r, tcp_est_r, half_close_r, time_wait_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_tmo_r <= RST_CLOSED_TMO;
      new_tmo_r    <= RST_NEW_TMO;
      udp_est_r    <= RST_UDP_EST;
      tcp_est_r    <= RST_TCP_EST;
      half_close_r <= RST_HALF_CLOSE;
      time_wait_r  <= RST_TIME_WAIT;
    end else if (cfg_valid && cfg_ready && (cfg_data != '0)) begin
      case (cfg_index)
        REG_CLOSED_TMO: closed_tmo_r <= cfg_data;
        REG_NEW_TMO:    new_tmo_r    <= cfg_data;
        REG_UDP_EST:    udp_est_r    <= cfg_data;
        REG_TCP_EST:    tcp_est_r    <= cfg_data;
        REG_HALF_CLOSE: half_close_r <= cfg_data;
        REG_TIME_WAIT:  time_wait_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing pass counter
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign status.clr_done = (clr_cnt_r == AW'(MAX_CONNS - 1));

  // item capture
  in_item_t item_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
  end

  // slot memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        rd_ent;
  logic [ENTRY_W-1:0] rdata;

  ctst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CONNS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (cmd.capture),
    .raddr   (AW'(in_item.slot)),
    .rdata_r (rdata)
  );

  assign rd_ent = entry_t'(rdata);

  // evaluation stage: next state, elapsed time, expiry threshold
  logic [3:0]       nst_r;
  logic [63:0]      diff_r;
  logic             nob_r;
  logic [THR_W-1:0] thr_r;
  logic [CFG_W-1:0] tmo;
  logic [CFG_W:0]   tmo_p1;
  logic [64:0]      sub;

  always_comb begin
    case (rd_ent.state)
      ST_NEW, ST_SIMSYN, ST_SYNRCVD: tmo = new_tmo_r;
      ST_EST: begin
        if (rd_ent.proto == PROTO_TCP) tmo = tcp_est_r;
        else if (rd_ent.proto == PROTO_UDP && rd_ent.dns) tmo = DNS_TMO_S;
        else tmo = udp_est_r;
      end
      ST_FINSENT, ST_FINRCVD, ST_CLOSEWAIT, ST_FINWAIT: tmo = half_close_r;
      ST_TIMEWAIT: tmo = time_wait_r;
      default: tmo = closed_tmo_r;
    endcase
    tmo_p1 = {1'b0, tmo} + (CFG_W+1)'(1);
    sub    = {1'b0, item_r.now_us} - {1'b0, rd_ent.last_us};
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      nst_r  <= next_state(rd_ent.state, rd_ent.proto, item_r.reverse_dir, item_r.flag_byte);
      diff_r <= sub[63:0];
      nob_r  <= ~sub[64];
      // whole seconds exceed tmo exactly when elapsed >= (tmo + 1) seconds
      thr_r  <= THR_W'(tmo_p1) * THR_W'(US_PER_S);
    end
  end

  // write-back and result
  logic      in_rng;
  logic      wb_we;
  entry_t    wb_ent;
  out_item_t res;
  logic      do_exp;

  always_comb begin
    in_rng = (32'(item_r.slot) < 32'(MAX_CONNS));
    do_exp = nob_r && (diff_r >= 64'(thr_r));
    wb_we  = 1'b0;
    wb_ent = rd_ent;
    res    = '0;
    if (rd_ent.valid) begin
      res.conn_state  = rd_ent.state;
      res.entry_valid = 1'b1;
    end
    case (item_r.command)
      CMD_CREATE: begin
        wb_we          = 1'b1;
        wb_ent.valid   = 1'b1;
        wb_ent.state   = ST_CLOSED;
        wb_ent.proto   = item_r.proto_class;
        wb_ent.dns     = (item_r.fwd_port == DNS_PORT);
        wb_ent.last_us = '0;
        res.conn_state  = ST_CLOSED;
        res.entry_valid = 1'b1;
      end
      CMD_PACKET: begin
        if (rd_ent.valid) begin
          wb_we          = 1'b1;
          wb_ent.state   = nst_r;
          wb_ent.last_us = item_r.now_us;
          res.conn_state = nst_r;
        end
      end
      CMD_AGE: begin
        if (rd_ent.valid && do_exp) begin
          wb_we        = 1'b1;
          wb_ent.valid = 1'b0;
          res          = '0;
          res.expired  = 1'b1;
        end
      end
      default: ;
    endcase
    if (!in_rng) begin
      wb_we = 1'b0;
      res   = '0;
    end
  end

  // memory write mux, clearing pass first
  always_comb begin
    if (cmd.clr_we) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.commit && wb_we;
      ram_waddr = AW'(item_r.slot);
      ram_wdata = wb_ent;
    end
  end

  // result register
  logic      out_strobe_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item_r <= res;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ===== rtl/core/ctst_chk.sv =====
// Port-level checker for the connection tracking state table, with its bind.
// Depends on ctst_pkg and tcp_udp_conntrack_state_table.
module ctst_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input ctst_pkg::out_item_t out_item
);
  import ctst_pkg::*;

  // an accepted item is followed by its result strobe
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("missing result three cycles after accept");

  // a result only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without preceding work");

  // an accepted item holds the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accept");

  // a freed or missing entry reports closed and no live connection
  a_free_is_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.expired || !out_item.entry_valid)) |->
      (!out_item.entry_valid && (out_item.conn_state == ST_CLOSED)))
    else $error("freed entry reports live state");

endmodule

bind tcp_udp_conntrack_state_table ctst_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
